// ----- rtl/assert_macros.svh -----
// Assertion helper macros shared by the index mapper RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BIM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bim_pkg.sv -----
// Shared types and constants for the broadcast index mapper.
// No dependencies; imported by every module of the block.
package bim_pkg;

    localparam int MAX_RANK = 4;
    localparam int DIM_BITS = 16;
    localparam int WORD_W   = 32;
    localparam int SHAPE_W  = 64;
    localparam int RANK_W   = 3;
    localparam int ADDR_W   = 6;
    localparam int IDX_W    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int CNT_W    = $clog2(WORD_W);

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_RANK   = 3'd0;
    localparam logic [2:0] REG_LSHAPE = 3'd1;
    localparam logic [2:0] REG_RSHAPE = 3'd2;
    localparam logic [2:0] REG_LBASE  = 3'd3;
    localparam logic [2:0] REG_RBASE  = 3'd4;

    // Reset shape: every dimension 1
    localparam logic [SHAPE_W-1:0] SHAPE_RST = 64'h0001_0001_0001_0001;

    typedef logic [WORD_W-1:0]                t_word;
    typedef logic [MAX_RANK-1:0][WORD_W-1:0]  t_word_arr;

    // Partial mapping handed from cell to cell
    typedef struct packed {
        t_word idx;
        t_word lsum;
        t_word rsum;
    } t_beat;

endpackage

// ----- rtl/bim_derive.sv -----
// Derives strides, result sub-sizes and result total from the shapes.
// One dimension per cycle for all MAX_RANK dimensions; depends on bim_pkg.
module bim_derive (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bim_pkg::RANK_W-1:0]   i_rank,
    input  logic [bim_pkg::SHAPE_W-1:0]  i_lshape,
    input  logic [bim_pkg::SHAPE_W-1:0]  i_rshape,
    output bim_pkg::t_word_arr           o_lstride,
    output bim_pkg::t_word_arr           o_rstride,
    output bim_pkg::t_word_arr           o_sub,
    output logic [bim_pkg::WORD_W:0]     o_total,
    output logic                         o_busy
);
    import bim_pkg::*;

    localparam logic [WORD_W:0] TOTAL_CAP = {1'b1, {WORD_W{1'b0}}};

    logic                r_busy;
    logic [IDX_W-1:0]    r_k;
    t_word               r_cl, r_cr, r_cres;
    logic [WORD_W:0]     r_total;
    t_word_arr           r_lstride, r_rstride, r_sub;

    logic [DIM_BITS-1:0] w_lfld, w_rfld, w_ld, w_rd, w_od;
    logic                w_use;
    logic [WORD_W+DIM_BITS:0] w_tprod;

    // Dimension fields of the current step, zero read as one
    always_comb begin
        w_lfld = i_lshape[r_k*DIM_BITS +: DIM_BITS];
        w_rfld = i_rshape[r_k*DIM_BITS +: DIM_BITS];
        w_ld   = (w_lfld == '0) ? DIM_BITS'(1) : w_lfld;
        w_rd   = (w_rfld == '0) ? DIM_BITS'(1) : w_rfld;
        w_od   = (w_ld > w_rd) ? w_ld : w_rd;
        w_use  = ({{(RANK_W-IDX_W){1'b0}}, r_k} < i_rank);
        w_tprod = r_total * w_od;
    end

    // Step sequencer with running products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy  <= 1'b1;
            r_k     <= '0;
            r_cl    <= WORD_W'(1);
            r_cr    <= WORD_W'(1);
            r_cres  <= WORD_W'(1);
            r_total <= (WORD_W+1)'(1);
        end else if (r_busy) begin
            if (w_use) begin
                r_lstride[r_k] <= (w_ld == DIM_BITS'(1)) ? '0 : r_cl;
                r_rstride[r_k] <= (w_rd == DIM_BITS'(1)) ? '0 : r_cr;
                r_sub[r_k]     <= r_cres;
                r_cl           <= WORD_W'(r_cl * w_ld);
                r_cr           <= WORD_W'(r_cr * w_rd);
                r_cres         <= WORD_W'(r_cres * w_od);
                if (!r_total[WORD_W]) begin
                    r_total <= (w_tprod > {{DIM_BITS{1'b0}}, TOTAL_CAP}) ?
                               TOTAL_CAP : w_tprod[WORD_W:0];
                end
            end else begin
                r_lstride[r_k] <= '0;
                r_rstride[r_k] <= '0;
                r_sub[r_k]     <= WORD_W'(1);
            end
            r_k <= r_k + IDX_W'(1);
            if (r_k == IDX_W'(MAX_RANK-1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_lstride = r_lstride;
    assign o_rstride = r_rstride;
    assign o_sub     = r_sub;
    assign o_total   = r_total;
    assign o_busy    = r_busy;

endmodule

// ----- rtl/bim_cell.sv -----
// One dimension cell: divides the running index by its sub-size and
// accumulates coordinate times stride; depends on bim_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bim_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  bim_pkg::t_word      i_sub,
    input  bim_pkg::t_word      i_lstride,
    input  bim_pkg::t_word      i_rstride,
    input  bim_pkg::t_beat      i_beat,
    input  logic                i_valid,
    output logic                o_ready,
    output bim_pkg::t_beat      o_beat,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_busy
);
    import bim_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_ADD, S_DONE} t_state;

    t_state             r_state;
    t_word              r_idx, r_lsum, r_rsum, r_quo, r_rem, r_lprod, r_rprod;
    logic [CNT_W-1:0]   r_cnt;

    logic [WORD_W:0]    w_trial;
    logic               w_ge;

    // Restoring division step
    always_comb begin
        w_trial = {r_rem, r_quo[WORD_W-1]};
        w_ge    = (w_trial >= {1'b0, i_sub});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_idx  <= i_beat.idx;
                        r_lsum <= i_beat.lsum;
                        r_rsum <= i_beat.rsum;
                        r_quo  <= i_beat.idx;
                        r_rem  <= '0;
                        r_cnt  <= CNT_W'(WORD_W-1);
                        // unused dimension or wrapped sub-size: pass through
                        r_state <= (!i_en || i_sub == '0) ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? WORD_W'(w_trial - {1'b0, i_sub}) : w_trial[WORD_W-1:0];
                    r_quo <= {r_quo[WORD_W-2:0], w_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_lprod <= WORD_W'(r_quo * i_lstride);
                    r_rprod <= WORD_W'(r_quo * i_rstride);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_lsum  <= r_lsum + r_lprod;
                    r_rsum  <= r_rsum + r_rprod;
                    r_idx   <= r_rem;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_DONE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_beat.idx  = r_idx;
    assign o_beat.lsum = r_lsum;
    assign o_beat.rsum = r_rsum;

    // Partial remainder never reaches the divisor
    `BIM_ASSERT_IMP(a_rem_below_sub, i_clk, i_rst_n, r_state == S_DIV, r_rem < i_sub, "cell remainder reached divisor")

endmodule

// ----- rtl/broadcast_index_mapper_unit.sv -----
// Top level of the broadcast index mapper: APB registers, derive sequencer,
// chain of dimension cells and output register; depends on bim_pkg, bim_derive, bim_cell.
//
// Usage:
//  - s_axis carries one flat result index per beat; m_axis returns the left
//    and right operand indices (base added, mod 2^32) and an in-range flag.
//  - One index is in flight at a time. It walks the cell chain from the
//    outermost dimension inward; each dimension in use takes a 32-step
//    bit-serial divide, a multiply, an accumulate and a hand-off, each
//    unused one only a hand-off. The next beat is taken at the earliest in
//    the cycle after the previous one has left the innermost cell.
//  - A register write restarts the derive pass (one dimension per cycle),
//    holding s_axis_tready low. Writes must be made while idle; unenforced.
//  - Reset loads rank 1, all dimensions 1, bases 0, then runs the derive pass.
//  - When m_axis_tready is low, the output register holds its beat, a new
//    beat may still be accepted and computed, and the innermost cell waits
//    until the output register is free.
`include "assert_macros.svh"
module broadcast_index_mapper_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bim_pkg::ADDR_W-1:0]    paddr,
    input  logic [bim_pkg::SHAPE_W-1:0]   pwdata,
    output logic [bim_pkg::SHAPE_W-1:0]   prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // [31:0] result_position
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [71:0]                   m_axis_tdata   // [31:0] left_position,
                                                         // [63:32] right_position,
                                                         // [64] in_range, rest 0
);
    import bim_pkg::*;

    logic [RANK_W-1:0]  r_rank;
    logic [SHAPE_W-1:0] r_lshape, r_rshape;
    t_word              r_lbase, r_rbase;

    logic               w_cfg_wr;
    logic [2:0]         w_reg;
    logic [RANK_W-1:0]  w_rank_eff;

    t_word_arr          w_lstride, w_rstride, w_sub;
    logic [WORD_W:0]    w_total;
    logic               w_der_busy;

    t_beat              w_link_beat  [MAX_RANK+1];
    logic               w_link_valid [MAX_RANK+1];
    logic               w_link_ready [MAX_RANK+1];
    logic [MAX_RANK-1:0] w_cell_busy;

    logic               r_inflight, r_inrange, r_out_valid;
    t_word              r_out_l, r_out_r;
    logic               r_out_inr;
    logic               w_in_acc, w_out_load;

    // Register file
    assign pready   = 1'b1;
    assign w_reg    = paddr[ADDR_W-1:3];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank   <= RANK_W'(1);
            r_lshape <= SHAPE_RST;
            r_rshape <= SHAPE_RST;
            r_lbase  <= '0;
            r_rbase  <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_RANK:   r_rank   <= pwdata[RANK_W-1:0];
                REG_LSHAPE: r_lshape <= pwdata;
                REG_RSHAPE: r_rshape <= pwdata;
                REG_LBASE:  r_lbase  <= pwdata[WORD_W-1:0];
                REG_RBASE:  r_rbase  <= pwdata[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_RANK:   prdata = {{(SHAPE_W-RANK_W){1'b0}}, r_rank};
            REG_LSHAPE: prdata = r_lshape;
            REG_RSHAPE: prdata = r_rshape;
            REG_LBASE:  prdata = {{(SHAPE_W-WORD_W){1'b0}}, r_lbase};
            REG_RBASE:  prdata = {{(SHAPE_W-WORD_W){1'b0}}, r_rbase};
            default:    prdata = '0;
        endcase
    end

    // Effective rank: zero reads as one, clipped to MAX_RANK
    always_comb begin
        if (r_rank == '0) begin
            w_rank_eff = RANK_W'(1);
        end else if (r_rank > RANK_W'(MAX_RANK)) begin
            w_rank_eff = RANK_W'(MAX_RANK);
        end else begin
            w_rank_eff = r_rank;
        end
    end

    bim_derive u_derive (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_cfg_wr),
        .i_rank    (w_rank_eff),
        .i_lshape  (r_lshape),
        .i_rshape  (r_rshape),
        .o_lstride (w_lstride),
        .o_rstride (w_rstride),
        .o_sub     (w_sub),
        .o_total   (w_total),
        .o_busy    (w_der_busy)
    );

    // Input beat enters the outermost cell
    assign s_axis_tready = !r_inflight && !w_der_busy && !w_cfg_wr &&
                           w_link_ready[MAX_RANK];
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign w_link_valid[MAX_RANK]     = w_in_acc;
    assign w_link_beat[MAX_RANK].idx  = s_axis_tdata;
    assign w_link_beat[MAX_RANK].lsum = '0;
    assign w_link_beat[MAX_RANK].rsum = '0;

    // Cell chain, cell k fed by cell k+1 (outermost dimension first)
    for (genvar k = 0; k < MAX_RANK; k++) begin : g_cell
        bim_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (RANK_W'(k) < w_rank_eff),
            .i_sub     (w_sub[k]),
            .i_lstride (w_lstride[k]),
            .i_rstride (w_rstride[k]),
            .i_beat    (w_link_beat[k+1]),
            .i_valid   (w_link_valid[k+1]),
            .o_ready   (w_link_ready[k+1]),
            .o_beat    (w_link_beat[k]),
            .o_valid   (w_link_valid[k]),
            .i_ready   (w_link_ready[k]),
            .o_busy    (w_cell_busy[k])
        );
    end

    // Output register
    assign w_link_ready[0] = !r_out_valid || m_axis_tready;
    assign w_out_load      = w_link_valid[0] && w_link_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_inflight <= 1'b1;
                r_inrange  <= ({1'b0, s_axis_tdata} < w_total);
            end else if (w_out_load) begin
                r_inflight <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out_l     <= w_link_beat[0].lsum + r_lbase;
                r_out_r     <= w_link_beat[0].rsum + r_rbase;
                r_out_inr   <= r_inrange;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_inr, r_out_r, r_out_l};

    // Derive pass blocks new beats right after a register write
    `BIM_ASSERT_NXT(a_cfg_blocks_input, i_clk, i_rst_n, w_cfg_wr, !s_axis_tready, "beat accepted during derive")
    // Only one cell works on a beat at a time
    `BIM_ASSERT_IMP(a_one_cell_busy, i_clk, i_rst_n, 1'b1, $onehot0(w_cell_busy), "several cells busy")
    // A busy cell implies a beat in flight
    `BIM_ASSERT_IMP(a_busy_inflight, i_clk, i_rst_n, w_cell_busy != '0, r_inflight, "cell busy with nothing in flight")

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for broadcast_index_mapper_unit: APB register writes,
// index stream in, operand index stream out, checked against a local predictor.
// Depends on bim_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;
    import bim_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [31:0] lpos;
        logic [31:0] rpos;
        logic        inr;
    } t_map;

    typedef struct {
        logic [31:0] pos;
        logic        known;
        t_map        res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [SHAPE_W-1:0] pwdata;
    logic [SHAPE_W-1:0] prdata;
    logic        pready;
    logic        s_axis_tvalid, s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [71:0] m_axis_tdata;

    // predictor copy of the registers and derived tables
    logic [2:0]  cfg_rank;
    logic [63:0] cfg_lshape, cfg_rshape;
    logic [31:0] cfg_lbase, cfg_rbase;
    logic [31:0] lstride [MAX_RANK];
    logic [31:0] rstride [MAX_RANK];
    logic [31:0] subsize [MAX_RANK];
    logic [32:0] total;

    t_map expected_maps [$];
    int   mismatches;
    bit   failed;
    bit   no_idle;
    bit   out_hold;
    int   idle_cycles;

    broadcast_index_mapper_unit DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int rank_in_use();
        if (cfg_rank == 3'd0) return 1;
        if (cfg_rank > MAX_RANK) return MAX_RANK;
        return int'(cfg_rank);
    endfunction

    function automatic logic [31:0] dim_at(logic [63:0] shape, int d);
        logic [15:0] v;
        v = shape[d*DIM_BITS +: DIM_BITS];
        return (v == 16'd0) ? 32'd1 : {16'd0, v};
    endfunction

    // rebuild strides, sub-sizes and saturated total from the registers
    task automatic derive_tables();
        logic [31:0] cl, cr, cres, ld, rd, od;
        logic [63:0] acc;
        int r;
        cl = 1; cr = 1; cres = 1; acc = 1;
        r = rank_in_use();
        for (int k = 0; k < MAX_RANK; k++) begin
            lstride[k] = 0; rstride[k] = 0; subsize[k] = 1;
        end
        for (int k = 0; k < r; k++) begin
            ld = dim_at(cfg_lshape, k);
            rd = dim_at(cfg_rshape, k);
            od = (ld > rd) ? ld : rd;
            lstride[k] = (ld == 1) ? 32'd0 : cl;
            rstride[k] = (rd == 1) ? 32'd0 : cr;
            subsize[k] = cres;
            cl = cl * ld; cr = cr * rd; cres = cres * od;
            if (acc < 64'h1_0000_0000) begin
                acc = acc * od;
                if (acc > 64'h1_0000_0000) acc = 64'h1_0000_0000;
            end
        end
        total = acc[32:0];
    endtask

    function automatic t_map map_position(logic [31:0] pos);
        logic [31:0] idx, coord, ls, rs;
        t_map m;
        idx = pos; ls = 0; rs = 0;
        for (int k = rank_in_use() - 1; k >= 1; k--) begin
            coord = 0;
            if (subsize[k] != 0) begin
                coord = idx / subsize[k];
                idx = idx % subsize[k];
            end
            ls += coord * lstride[k];
            rs += coord * rstride[k];
        end
        ls += idx * lstride[0];
        rs += idx * rstride[0];
        m.lpos = ls + cfg_lbase;
        m.rpos = rs + cfg_rbase;
        m.inr  = ({1'b0, pos} < total);
        return m;
    endfunction

    // APB write: setup then access, mirrored into the predictor
    task automatic reg_write(logic [2:0] reg_idx, logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(reg_idx) << 3; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (reg_idx)
            REG_RANK:   cfg_rank   = value[2:0];
            REG_LSHAPE: cfg_lshape = value;
            REG_RSHAPE: cfg_rshape = value;
            REG_LBASE:  cfg_lbase  = value[31:0];
            REG_RBASE:  cfg_rbase  = value[31:0];
            default: ;
        endcase
        derive_tables();
    endtask

    task automatic write_all(logic [2:0] rk, logic [63:0] ls, logic [63:0] rs,
                             logic [31:0] lb, logic [31:0] rb);
        s_axis_tvalid <= 1'b0;
        wait (expected_maps.size() == 0);
        reg_write(REG_RANK, {61'd0, rk});
        reg_write(REG_LSHAPE, ls);
        reg_write(REG_RSHAPE, rs);
        reg_write(REG_LBASE, {32'd0, lb});
        reg_write(REG_RBASE, {32'd0, rb});
    endtask

    // send one index beat, with a random gap before it unless idling is off;
    // tvalid stays high for a following beat, callers drop it when they pause
    task automatic send_index(logic [31:0] pos, logic known, t_map res);
        t_map m;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pos;
        m = map_position(pos);
        if (known) m = res;
        expected_maps.push_back(m);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [63:0] rand_shape(int maxd);
        logic [63:0] s;
        for (int d = 0; d < 4; d++) begin
            case ($urandom_range(0, 3))
                0: s[d*16 +: 16] = 16'd1;
                1: s[d*16 +: 16] = 16'd0;
                default: s[d*16 +: 16] = 16'($urandom_range(1, maxd));
            endcase
        end
        return s;
    endfunction

    // receiver: random stalls, long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (out_hold) begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
                out_hold = 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_map exp_m, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.lpos = m_axis_tdata[31:0];
            got.rpos = m_axis_tdata[63:32];
            got.inr  = m_axis_tdata[64];
            if (expected_maps.size() == 0) begin
                failed = 1'b1;
                if (mismatches < 10) $display("unexpected beat %h", m_axis_tdata);
                mismatches++;
            end else begin
                exp_m = expected_maps.pop_front();
                if (got !== exp_m || m_axis_tdata[71:65] !== 7'd0) begin
                    failed = 1'b1;
                    if (mismatches < 10)
                        $display("mismatch: exp l=%h r=%h in=%b got l=%h r=%h in=%b",
                                 exp_m.lpos, exp_m.rpos, exp_m.inr,
                                 got.lpos, got.rpos, got.inr);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no beat accepted on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        t_row row;
        t_map none;
        int r;
        none = '0;
        failed = 0; mismatches = 0; no_idle = 0; out_hold = 0; idle_cycles = 0;
        i_rst_n = 1'b0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_axis_tvalid = 0; s_axis_tdata = '0;
        cfg_rank = 3'd1; cfg_lshape = SHAPE_RST; cfg_rshape = SHAPE_RST;
        cfg_lbase = 0; cfg_rbase = 0;
        derive_tables();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: total 1, strides 0
        rows.push_back('{32'd0, 1'b1, '{32'd0, 32'd0, 1'b1}});
        rows.push_back('{32'd1, 1'b1, '{32'd0, 32'd0, 1'b0}});
        rows.push_back('{32'hFFFF_FFFF, 1'b1, '{32'd0, 32'd0, 1'b0}});
        foreach (rows[i]) send_index(rows[i].pos, rows[i].known, rows[i].res);
        rows.delete();

        // broadcast 3x4 against 1x4, bases set
        write_all(3'd2, 64'h0000_0000_0003_0004, 64'h0000_0000_0001_0004,
                  32'd100, 32'hFFFF_FFFF);
        for (int p = 0; p < 13; p++) send_index(p, 1'b0, none);
        // rank 0 read as 1; rank 7 read as max; huge dims saturate the total
        write_all(3'd0, 64'h0000_0000_0000_0005, 64'h0000_0000_0000_0000, 32'd0, 32'd0);
        send_index(32'd4, 1'b1, '{32'd4, 32'd0, 1'b1});
        send_index(32'd5, 1'b1, '{32'd5, 32'd0, 1'b0});
        write_all(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0001_FFFF_0001_FFFF,
                  32'hFFFF_FFFF, 32'hAAAA_5555);
        send_index(32'hFFFF_FFFF, 1'b0, none);
        send_index(32'h8000_0000, 1'b0, none);
        send_index(32'h0001_2345, 1'b0, none);
        write_all(3'd4, 64'h0002_0003_0004_0005, 64'h0002_0001_0004_0001, 32'd7, 32'd9);
        send_index(32'd119, 1'b0, none);
        send_index(32'd120, 1'b0, none);

        // random phases with random configurations
        for (int ph = 0; ph < 10; ph++) begin
            r = $urandom_range(0, 7);
            write_all(r[2:0], rand_shape(ph < 8 ? 7 : 65535),
                      rand_shape(ph < 8 ? 7 : 65535), $urandom, $urandom);
            if (ph == 3) begin
                out_hold = 1'b1;
                @(posedge i_clk);
            end
            if (ph == 8) no_idle = 1'b1;
            for (int n = 0; n < 38; n++) begin
                case ($urandom_range(0, 4))
                    0: send_index($urandom, 1'b0, none);
                    1: send_index(total[32] ? $urandom : total[31:0] - 1, 1'b0, none);
                    default: send_index(total[32] ? $urandom :
                                        $urandom_range(0, total[31:0]), 1'b0, none);
                endcase
                if (ph == 5 && n == 19) begin
                    s_axis_tvalid <= 1'b0;
                    wait (expected_maps.size() == 0);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        wait (expected_maps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed && expected_maps.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bim_pkg.sv
rtl/bim_derive.sv
rtl/bim_cell.sv
rtl/broadcast_index_mapper_unit.sv
tb/sv/tb_top.sv
